>>> rtl/core/sdr_pkg.sv
package sdr_pkg;

  localparam int IN_SET_W  = 11;
  localparam int IN_WAY_W  = 4;
  localparam int PC_W      = 18;
  localparam int DRAW_W    = 5;
  localparam int PC_SHIFT1 = 6;
  localparam int PC_SHIFT2 = 12;
  localparam int REUSE_W   = 2;

  localparam logic [REUSE_W-1:0] REUSE_MAX    = 2'd3;
  localparam logic [REUSE_W-1:0] REUSE_THRESH = 2'd1;
  localparam logic [REUSE_W-1:0] REUSE_INIT   = 2'd1;

  localparam logic FUNC_VICTIM = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic                func;
    logic [IN_SET_W-1:0] set_index;
    logic [IN_WAY_W-1:0] way;
    logic [PC_W-1:0]     pc_low;
    logic                hit;
    logic [DRAW_W-1:0]   chance_draw;
  } sdr_in_t;

  typedef struct packed {
    logic [IN_WAY_W-1:0] victim_way;
    logic                found_distant;
  } sdr_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_LOAD,
    ST_EXEC
  } sdr_state_t;

  typedef enum logic [1:0] {
    KIND_FOLLOW,
    KIND_LIP,
    KIND_BIP
  } sdr_kind_t;

  typedef struct packed {
    logic clear_step;
    logic take_in;
    logic div;
    logic rd;
    logic load;
    logic exec;
  } sdr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sdr_sts_t;

endpackage

>>> rtl/core/sdr_ram.sv
module sdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/sdr_ctrl.sv
module sdr_ctrl
  import sdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sdr_sts_t sts,
  output sdr_cmd_t cmd
);

  sdr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

>>> rtl/core/sdr_dp.sv
module sdr_dp
  import sdr_pkg::*;
#(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int LEADER_SETS    = 64,
  parameter int SIGNATURE_BITS = 6,
  parameter int SELECTOR_BITS  = 10,
  parameter int AGE_BITS       = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  sdr_cmd_t cmd,
  output sdr_sts_t sts,
  input  sdr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sdr_out_t out_data
);

  localparam int SET_W     = $clog2(NUM_SETS);
  localparam int WAY_W     = $clog2(NUM_WAYS);
  localparam int SIG_W     = SIGNATURE_BITS;
  localparam int SIG_CNT   = 1 << SIG_W;
  localparam int AROW_W    = NUM_WAYS * AGE_BITS;
  localparam int SROW_W    = NUM_WAYS * SIG_W;
  localparam int CLR_CNT   = (NUM_SETS > SIG_CNT) ? NUM_SETS : SIG_CNT;
  localparam int CLR_W     = $clog2(CLR_CNT);
  localparam int MW        = IN_SET_W + 1;
  localparam int MP_W      = 2 * MW;
  localparam int RECIP_SET = (1 << IN_SET_W) / NUM_SETS;
  localparam int QS_W      = 7;
  localparam int STRIDE    = NUM_SETS / LEADER_SETS;
  localparam int STRIDE_E  = (STRIDE == 0) ? 1 : STRIDE;
  localparam int LRECIP    = (1 << SET_W) / STRIDE_E;
  localparam int LQ_W      = SET_W + 1;
  localparam int LP_W      = 2 * SET_W + 2;

  localparam logic [AGE_BITS-1:0]      AGE_MAX  = {AGE_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SEL_MAX >> 1;

  sdr_in_t                  item_r;
  logic [QS_W-1:0]          q0_r;
  logic [SET_W-1:0]         set_r;
  logic [LQ_W-1:0]          lq0_r;
  logic [AROW_W-1:0]        age_row_r;
  logic [SROW_W-1:0]        sig_row_r;
  logic [REUSE_W-1:0]       reuse_new_r;
  logic [SIG_W-1:0]         sig_r;
  logic [SIG_W-1:0]         old_sig_r;
  logic [SELECTOR_BITS-1:0] duel_r, duel_nxt;
  logic [CLR_W-1:0]         clr_r;
  logic                     out_valid_r;
  sdr_out_t                 out_r, res_c;

  logic [AROW_W-1:0]  age_rdata, age_wdata;
  logic [SROW_W-1:0]  sig_rdata, sig_wdata;
  logic [REUSE_W-1:0] reuse_rdata, reuse_wdata;
  logic [SET_W-1:0]   age_waddr, set_c;
  logic [SIG_W-1:0]   reuse_waddr, reuse_raddr, sig_c, old_sig_c;
  logic               age_we, sig_we, reuse_we;

  logic [MW-1:0]      r0_set;
  logic [LQ_W-1:0]    lr0, lr, lq;
  sdr_kind_t          kind;
  logic [WAY_W-1:0]   way_i;
  logic               way_ok;
  logic               found1, found2;
  logic [WAY_W-1:0]   vic1, vic2;
  logic [AROW_W-1:0]  aged_row, upd_age_row;
  logic [SROW_W-1:0]  upd_sig_row;
  logic [REUSE_W-1:0] dec_old, sig_cnt_eff;
  logic               use_bip;
  logic [AGE_BITS-1:0] ins_age;

  function automatic logic [PC_W-1:0] in_data_sig(input logic [PC_W-1:0] pc);
    in_data_sig = pc ^ (pc >> PC_SHIFT1) ^ (pc >> PC_SHIFT2);
  endfunction

  assign sig_c = SIG_W'(in_data_sig(item_r.pc_low));

  assign r0_set = {1'b0, item_r.set_index} - MW'(int'(q0_r) * NUM_SETS);
  always_comb begin
    if (32'(r0_set) >= 32'(NUM_SETS)) begin
      set_c = SET_W'(r0_set - MW'(NUM_SETS));
    end else begin
      set_c = SET_W'(r0_set);
    end
  end

  assign way_i     = WAY_W'(item_r.way);
  assign way_ok    = 32'(item_r.way) < 32'(NUM_WAYS);
  assign old_sig_c = sig_rdata[way_i*SIG_W +: SIG_W];

  always_comb begin
    lr0 = LQ_W'({1'b0, set_r}) - LQ_W'(int'(lq0_r) * STRIDE_E);
    if (32'(lr0) >= 32'(STRIDE_E)) begin
      lr = lr0 - LQ_W'(STRIDE_E);
      lq = lq0_r + LQ_W'(1);
    end else begin
      lr = lr0;
      lq = lq0_r;
    end
    if (STRIDE == 0) begin
      kind = (set_r == '0) ? KIND_BIP : KIND_FOLLOW;
    end else if (32'(lq) >= 32'(LEADER_SETS)) begin
      kind = KIND_FOLLOW;
    end else if (32'(lr) == 32'(STRIDE_E / 2)) begin
      kind = KIND_BIP;
    end else if (lr == '0) begin
      kind = KIND_LIP;
    end else begin
      kind = KIND_FOLLOW;
    end
  end

  always_comb begin
    found1   = 1'b0;
    found2   = 1'b0;
    vic1     = '0;
    vic2     = '0;
    aged_row = age_row_r;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (age_row_r[w*AGE_BITS +: AGE_BITS] == AGE_MAX) begin
        found1 = 1'b1;
        vic1   = WAY_W'(w);
      end
      if (age_row_r[w*AGE_BITS +: AGE_BITS] == AGE_MAX - AGE_BITS'(1)) begin
        found2 = 1'b1;
        vic2   = WAY_W'(w);
      end
      if (age_row_r[w*AGE_BITS +: AGE_BITS] != AGE_MAX) begin
        aged_row[w*AGE_BITS +: AGE_BITS] = age_row_r[w*AGE_BITS +: AGE_BITS] + AGE_BITS'(1);
      end
    end
  end

  always_comb begin
    dec_old     = (reuse_rdata != '0) ? reuse_rdata - REUSE_W'(1) : reuse_rdata;
    sig_cnt_eff = (sig_r == old_sig_r) ? dec_old : reuse_new_r;
    unique case (kind)
      KIND_LIP: use_bip = 1'b0;
      KIND_BIP: use_bip = 1'b1;
      default:  use_bip = duel_r < SEL_HALF;
    endcase
    ins_age = AGE_MAX;
    if (use_bip && item_r.chance_draw == '0) begin
      ins_age = '0;
    end
    if (sig_cnt_eff >= REUSE_THRESH) begin
      ins_age = '0;
    end
    upd_age_row = age_row_r;
    upd_sig_row = sig_row_r;
    upd_sig_row[way_i*SIG_W +: SIG_W] = sig_r;
    if (item_r.hit) begin
      upd_age_row[way_i*AGE_BITS +: AGE_BITS] = '0;
    end else begin
      upd_age_row[way_i*AGE_BITS +: AGE_BITS] = ins_age;
    end
    duel_nxt = duel_r;
    if (item_r.hit && kind == KIND_LIP && duel_r != SEL_MAX) begin
      duel_nxt = duel_r + SELECTOR_BITS'(1);
    end else if (item_r.hit && kind == KIND_BIP && duel_r != '0) begin
      duel_nxt = duel_r - SELECTOR_BITS'(1);
    end
  end

  always_comb begin
    res_c = '0;
    if (item_r.func == FUNC_VICTIM) begin
      if (found1) begin
        res_c.victim_way    = IN_WAY_W'(vic1);
        res_c.found_distant = 1'b1;
      end else if (found2) begin
        res_c.victim_way    = IN_WAY_W'(vic2);
        res_c.found_distant = 1'b1;
      end
    end
  end

  always_comb begin
    age_we      = 1'b0;
    sig_we      = 1'b0;
    reuse_we    = 1'b0;
    age_waddr   = set_r;
    age_wdata   = upd_age_row;
    sig_wdata   = upd_sig_row;
    reuse_waddr = item_r.hit ? sig_r : old_sig_r;
    reuse_wdata = item_r.hit ? ((reuse_new_r != REUSE_MAX) ? reuse_new_r + REUSE_W'(1)
                                                            : reuse_new_r)
                             : dec_old;
    if (cmd.clear_step) begin
      age_waddr   = SET_W'(clr_r);
      age_wdata   = {NUM_WAYS{AGE_MAX}};
      sig_wdata   = '0;
      reuse_waddr = SIG_W'(clr_r);
      reuse_wdata = REUSE_INIT;
      age_we      = 32'(clr_r) < 32'(NUM_SETS);
      sig_we      = age_we;
      reuse_we    = 32'(clr_r) < 32'(SIG_CNT);
    end else if (cmd.exec) begin
      if (item_r.func == FUNC_VICTIM) begin
        age_we    = !found1;
        age_wdata = aged_row;
      end else begin
        age_we   = way_ok;
        sig_we   = way_ok;
        reuse_we = way_ok;
      end
    end
  end

  always_comb begin
    if (cmd.rd) begin
      reuse_raddr = sig_c;
    end else if (cmd.load) begin
      reuse_raddr = old_sig_c;
    end else begin
      reuse_raddr = old_sig_r;
    end
  end

  sdr_ram #(.WIDTH(AROW_W), .DEPTH(NUM_SETS)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (set_c),
    .rdata (age_rdata)
  );

  sdr_ram #(.WIDTH(SROW_W), .DEPTH(NUM_SETS)) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (age_waddr),
    .wdata (sig_wdata),
    .raddr (set_c),
    .rdata (sig_rdata)
  );

  sdr_ram #(.WIDTH(REUSE_W), .DEPTH(SIG_CNT)) u_reuse_ram (
    .clk   (clk),
    .we    (reuse_we),
    .waddr (reuse_waddr),
    .wdata (reuse_wdata),
    .raddr (reuse_raddr),
    .rdata (reuse_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item_r <= in_data;
    end
    if (cmd.div) begin
      q0_r <= QS_W'((MP_W'(item_r.set_index) * MP_W'(RECIP_SET)) >> IN_SET_W);
    end
    if (cmd.rd) begin
      set_r <= set_c;
      sig_r <= sig_c;
    end
    if (cmd.load) begin
      age_row_r   <= age_rdata;
      sig_row_r   <= sig_rdata;
      reuse_new_r <= reuse_rdata;
      old_sig_r   <= old_sig_c;
      lq0_r       <= LQ_W'((LP_W'(set_r) * LP_W'(LRECIP)) >> SET_W);
    end
    if (cmd.exec) begin
      out_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      duel_r      <= SEL_HALF;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      if (cmd.exec && item_r.func == FUNC_UPDATE && way_ok) begin
        duel_r <= duel_nxt;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clear_last = clr_r == CLR_W'(CLR_CNT - 1);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

>>> rtl/core/ship_dip_rrip_replacement.sv
// Channel   Ports                          Beat
// input     in_valid in_ready in_data      one access (victim request or update)
// result    out_valid out_ready out_data   victim way and found flag, one per access
//
// An access steps through accept, set-index reduction, row read,
// reuse-counter read for the old signature, then write-back and result.
// After reset the set rows and reuse counters are swept, one entry a cycle,
// with in_ready low. A waiting result holds the block in its last step until
// out_ready.
module ship_dip_rrip_replacement
  import sdr_pkg::*;
#(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int LEADER_SETS    = 64,
  parameter int SIGNATURE_BITS = 6,
  parameter int SELECTOR_BITS  = 10,
  parameter int AGE_BITS       = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sdr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sdr_out_t out_data
);

  sdr_cmd_t cmd;
  sdr_sts_t sts;

  sdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdr_dp #(
    .NUM_SETS       (NUM_SETS),
    .NUM_WAYS       (NUM_WAYS),
    .LEADER_SETS    (LEADER_SETS),
    .SIGNATURE_BITS (SIGNATURE_BITS),
    .SELECTOR_BITS  (SELECTOR_BITS),
    .AGE_BITS       (AGE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/ship_dip_rrip_replacement_tb.sv
module ship_dip_rrip_replacement_tb;
  import sdr_pkg::*;

  localparam int NSETS   = 2048;
  localparam int NWAYS   = 16;
  localparam int NLEAD   = 64;
  localparam int SIGB    = 6;
  localparam int SELB    = 10;
  localparam int AGEB    = 2;
  localparam int STRIDE  = NSETS / NLEAD;
  localparam logic [AGEB-1:0] AGE_TOP = '1;
  localparam logic [SELB-1:0] SEL_TOP = '1;
  localparam int LIMIT   = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sdr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sdr_out_t out_data;

  ship_dip_rrip_replacement i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  logic [AGEB-1:0]  age_mem [NSETS*NWAYS];
  logic [SIGB-1:0]  sig_mem [NSETS*NWAYS];
  logic [1:0]       reuse_mem [2**SIGB];
  logic [SELB-1:0]  duel_sel;

  sdr_out_t victim_q[$];
  int  errors = 0;
  int  cycles = 0;
  int  n_victims;
  int  n_updates;
  bit  sink_stall_en;
  bit  src_gap_en;
  bit  hold_sink;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL ship_dip_rrip_replacement");
      $finish;
    end
  end

  function automatic sdr_kind_t set_kind(int s);
    int q;
    int r;
    q = s / STRIDE;
    r = s % STRIDE;
    if (q >= NLEAD) return KIND_FOLLOW;
    if (r == STRIDE / 2) return KIND_BIP;
    if (r == 0) return KIND_LIP;
    return KIND_FOLLOW;
  endfunction

  function automatic sdr_out_t replace_access(sdr_in_t a);
    sdr_out_t r;
    int base;
    int idx;
    logic [SIGB-1:0] sg;
    logic [SIGB-1:0] old;
    logic [AGEB-1:0] ins;
    sdr_kind_t k;
    bit bip;
    r = '0;
    base = (int'(a.set_index) % NSETS) * NWAYS;
    if (a.func == FUNC_VICTIM) begin
      for (int w = 0; w < NWAYS; w++)
        if (age_mem[base+w] == AGE_TOP) begin
          r.victim_way = IN_WAY_W'(w);
          r.found_distant = 1'b1;
          return r;
        end
      for (int w = 0; w < NWAYS; w++)
        if (age_mem[base+w] < AGE_TOP) age_mem[base+w] = age_mem[base+w] + AGEB'(1);
      for (int w = 0; w < NWAYS; w++)
        if (age_mem[base+w] == AGE_TOP) begin
          r.victim_way = IN_WAY_W'(w);
          r.found_distant = 1'b1;
          return r;
        end
      return r;
    end
    if (int'(a.way) >= NWAYS) return r;
    sg = SIGB'(a.pc_low ^ (a.pc_low >> PC_SHIFT1) ^ (a.pc_low >> PC_SHIFT2));
    idx = base + int'(a.way);
    k = set_kind(int'(a.set_index) % NSETS);
    if (a.hit) begin
      age_mem[idx] = '0;
      sig_mem[idx] = sg;
      if (reuse_mem[sg] < REUSE_MAX) reuse_mem[sg]++;
      if (k == KIND_LIP && duel_sel < SEL_TOP) duel_sel++;
      else if (k == KIND_BIP && duel_sel > 0) duel_sel--;
    end else begin
      old = sig_mem[idx];
      if (reuse_mem[old] > 0) reuse_mem[old]--;
      if (k == KIND_LIP) bip = 1'b0;
      else if (k == KIND_BIP) bip = 1'b1;
      else bip = duel_sel < SEL_TOP / 2;
      ins = AGE_TOP;
      if (bip && a.chance_draw == 0) ins = '0;
      if (reuse_mem[sg] >= REUSE_THRESH) ins = '0;
      age_mem[idx] = ins;
      sig_mem[idx] = sg;
    end
    return r;
  endfunction

  // sink: random stall bursts, or one long hold
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        @(negedge clk);
      end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (victim_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        sdr_out_t e;
        e = victim_q.pop_front();
        if (out_data.victim_way !== e.victim_way) begin
          $error("victim_way expected %0d actual %0d", e.victim_way, out_data.victim_way);
          errors++;
        end
        if (out_data.found_distant !== e.found_distant) begin
          $error("found_distant expected %0d actual %0d", e.found_distant,
                 out_data.found_distant);
          errors++;
        end
      end
    end
  end

  task automatic send_access(sdr_in_t a);
    int n;
    if (src_gap_en && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    victim_q.push_back(replace_access(a));
    if (a.func == FUNC_VICTIM) n_victims++;
    else n_updates++;
    @(negedge clk);
  endtask

  function automatic sdr_in_t mk(logic f, int s, int w, logic [PC_W-1:0] pc, logic h,
                                 int d);
    sdr_in_t a;
    a.func = f;
    a.set_index = IN_SET_W'(s);
    a.way = IN_WAY_W'(w);
    a.pc_low = pc;
    a.hit = h;
    a.chance_draw = DRAW_W'(d);
    return a;
  endfunction

  function automatic sdr_in_t rand_access(int set_hi);
    sdr_in_t a;
    a.func = 1'($urandom_range(0, 1));
    a.set_index = IN_SET_W'($urandom_range(0, set_hi));
    a.way = IN_WAY_W'($urandom_range(0, 15));
    a.pc_low = PC_W'($urandom);
    a.hit = 1'($urandom_range(0, 1));
    a.chance_draw = DRAW_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31));
    return a;
  endfunction

  task automatic test_directed();
    send_access(mk(FUNC_VICTIM, 0, 0, 18'h0, 1'b0, 0));
    send_access(mk(FUNC_VICTIM, 2047, 15, 18'h3FFFF, 1'b1, 31));
    for (int w = 0; w < NWAYS; w++)
      send_access(mk(FUNC_UPDATE, 5, w, 18'h3FFFF, 1'b1, 31));
    send_access(mk(FUNC_VICTIM, 5, 0, 18'h0, 1'b0, 0));
    send_access(mk(FUNC_VICTIM, 5, 0, 18'h0, 1'b0, 0));
    send_access(mk(FUNC_UPDATE, 0, 3, 18'h2AAAA, 1'b0, 0));
    send_access(mk(FUNC_UPDATE, STRIDE/2, 4, 18'h15555, 1'b0, 0));
    send_access(mk(FUNC_UPDATE, STRIDE/2, 4, 18'h15555, 1'b1, 0));
    send_access(mk(FUNC_UPDATE, 0, 3, 18'h00040, 1'b1, 7));
    send_access(mk(FUNC_UPDATE, 7, 9, 18'h01000, 1'b0, 16));
  endtask

  task automatic test_leader_duel();
    for (int i = 0; i < 120; i++)
      send_access(mk(FUNC_UPDATE, (i % 8) * STRIDE + STRIDE/2, $urandom_range(0, 15),
                     PC_W'($urandom), 1'b1, $urandom_range(0, 31)));
    for (int i = 0; i < 60; i++)
      send_access(rand_access(63));
  endtask

  task automatic test_backpressure();
    int n;
    hold_sink = 1'b1;
    fork
      begin
        n = 0;
        while (n < 60) begin
          @(posedge clk);
          n++;
        end
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_access(rand_access(NSETS-1));
    join
  endtask

  task automatic test_random();
    for (int i = 0; i < 450; i++)
      send_access(rand_access(($urandom_range(0, 3) == 0) ? NSETS-1 : 31));
  endtask

  task automatic test_no_idle();
    src_gap_en = 1'b0;
    sink_stall_en = 1'b0;
    for (int i = 0; i < 180; i++) send_access(rand_access(15));
  endtask

  initial begin
    n_victims = 0;
    n_updates = 0;
    hold_sink = 1'b0;
    src_gap_en = 1'b1;
    sink_stall_en = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      age_mem[i] = AGE_TOP;
      sig_mem[i] = '0;
    end
    for (int i = 0; i < 2**SIGB; i++) reuse_mem[i] = REUSE_INIT;
    duel_sel = SEL_TOP / 2;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_leader_duel();
    test_backpressure();
    test_random();
    test_no_idle();
    in_valid <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d victim requests and %0d updates, leader duel and long stall",
             n_victims, n_updates);
    if (errors == 0) $display("PASS ship_dip_rrip_replacement");
    else $display("FAIL ship_dip_rrip_replacement");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sdr_pkg.sv
rtl/core/sdr_ram.sv
rtl/core/sdr_ctrl.sv
rtl/core/sdr_dp.sv
rtl/core/ship_dip_rrip_replacement.sv
dv/ship_dip_rrip_replacement_tb.sv
